// File: src/nrrt_pkg.sv
// ----------------------------------------------------------------------------
// nrrt_pkg: shared codes for the narrowest range route table
// operation codes and result status codes used by the block and its checker
// ----------------------------------------------------------------------------
`default_nettype none

package nrrt_pkg;

	// table operations
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_UPDATE = 2'd1,
		OP_REMOVE = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	// result status
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_UNKNOWN   = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	localparam int NODE_W = 64;
	localparam int GW_PORT_W = 16;

endpackage

`default_nettype wire

// File: src/nrrt_ram.sv
// ----------------------------------------------------------------------------
// nrrt_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module nrrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: src/narrowest_range_route_table_top.sv
// ----------------------------------------------------------------------------
// narrowest_range_route_table_top: node range to gateway route table
// add, update, remove and narrowest-match lookup over a scanned table ram
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | fields
//  ----------+----------------------+------------------------------------------
//  command   | start, busy          | operation, range_first, range_last,
//            |                      | lookup_node, gateway_in
//  result    | done (1-cycle pulse) | status, gateway_out
//
//  a command whose range or node is invalid on its face (add with first node
//  zero or first above last, lookup of node zero) answers on the next cycle
//  and leaves busy low.
//  every other command scans the whole table, one ram row per cycle, through
//  a two-stage compare pipe and then a finish state; busy is low again in the
//  cycle done is shown. the ram read port sets the rate.
//  after reset a clearing pass writes every row empty with busy high.
//  the receiver cannot stall: each result is taken in its one done cycle.
//
`default_nettype none

module narrowest_range_route_table_top #(
	parameter int TABLE_ENTRIES = 64,
	parameter int GATEWAY_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [63:0] range_first,
	input  wire logic [63:0] range_last,
	input  wire logic [63:0] lookup_node,
	input  wire logic [15:0] gateway_in,
	output logic             done,
	output logic [2:0]       status,
	output logic [15:0]      gateway_out
);

	localparam int NW    = nrrt_pkg::NODE_W;
	localparam int GW_W  = GATEWAY_BITS;
	localparam int AW    = $clog2(TABLE_ENTRIES);
	localparam int CW    = $clog2(TABLE_ENTRIES + 1);
	// row layout: {valid, first, last, gateway}
	localparam int ROW_W = 1 + 2 * NW + GW_W;
	localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	// latched command
	nrrt_pkg::op_t   op_q;
	logic [NW-1:0]   first_q;
	logic [NW-1:0]   last_q;
	logic [NW-1:0]   node_q;
	logic [GW_W-1:0] gw_q;

	// row counter, shared by clearing pass and scan
	logic [CW-1:0] cnt_q;

	// scan pipe: s1 is ram read data, s2 is compare results
	logic            v_s1, last_s1;
	logic [AW-1:0]   idx_s1;
	logic            v_s2, last_s2;
	logic [AW-1:0]   idx_s2;
	logic            used_s2, match_s2, contain_s2;
	logic [NW-1:0]   size_s2, first_s2;
	logic [GW_W-1:0] gw_s2;

	// scan results
	logic            match_found_q, free_found_q, best_found_q;
	logic [AW-1:0]   match_idx_q, free_idx_q;
	logic [NW-1:0]   best_size_q, best_first_q;
	logic [GW_W-1:0] best_gw_q;

	// result register
	logic                done_q;
	nrrt_pkg::status_t   status_q;
	logic [GW_W-1:0]     gw_out_q;

	// ram ports
	logic             wr_en, rd_en;
	logic [AW-1:0]    wr_addr;
	logic [ROW_W-1:0] wr_data, rd_data;

	// command decode
	logic accept, face_invalid;

	// row fields of the ram read data
	logic            r_valid;
	logic [NW-1:0]   r_first, r_last;
	logic [GW_W-1:0] r_gw;

	// finish decision
	logic              fin_wr;
	logic [AW-1:0]     fin_addr;
	logic [ROW_W-1:0]  fin_row;
	nrrt_pkg::status_t fin_status;
	logic [GW_W-1:0]   fin_gw;

	logic better;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);

	// rejects that need no table access
	assign face_invalid =
		((nrrt_pkg::op_t'(operation) == nrrt_pkg::OP_ADD) &&
		 ((range_first == '0) || (range_first > range_last))) ||
		((nrrt_pkg::op_t'(operation) == nrrt_pkg::OP_LOOKUP) && (lookup_node == '0));

	assign {r_valid, r_first, r_last, r_gw} = rd_data;

	// issue one read per scan cycle
	assign rd_en = (state_q == S_SCAN) && (cnt_q != CNT_END);

	// end-of-scan decision per operation
	always_comb begin
		fin_wr     = 1'b0;
		fin_addr   = match_idx_q;
		fin_row    = {1'b1, first_q, last_q, gw_q};
		fin_status = nrrt_pkg::ST_OK;
		fin_gw     = '0;
		unique case (op_q)
			nrrt_pkg::OP_ADD: begin
				fin_addr = free_idx_q;
				if (match_found_q) begin
					fin_status = nrrt_pkg::ST_DUPLICATE;
				end else if (!free_found_q) begin
					fin_status = nrrt_pkg::ST_FULL;
				end else begin
					fin_wr = 1'b1;
				end
			end
			nrrt_pkg::OP_UPDATE: begin
				if (match_found_q) begin
					fin_wr = 1'b1;
				end else begin
					fin_status = nrrt_pkg::ST_UNKNOWN;
				end
			end
			nrrt_pkg::OP_REMOVE: begin
				fin_row = '0;
				if (match_found_q) begin
					fin_wr = 1'b1;
				end else begin
					fin_status = nrrt_pkg::ST_UNKNOWN;
				end
			end
			nrrt_pkg::OP_LOOKUP: begin
				if (best_found_q) begin
					fin_gw = best_gw_q;
				end else begin
					fin_status = nrrt_pkg::ST_UNKNOWN;
				end
			end
			default: begin
				fin_status = nrrt_pkg::ST_UNKNOWN;
			end
		endcase
	end

	// write port: empty rows while clearing, table change at finish
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = '0;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == S_FINISH) begin
			wr_en   = fin_wr;
			wr_addr = fin_addr;
			wr_data = fin_row;
		end
	end

	// narrower range wins, equal size goes to the lower first node
	assign better = !best_found_q || (size_s2 < best_size_q) ||
		((size_s2 == best_size_q) && (first_s2 < best_first_q));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			cnt_q         <= '0;
			v_s1          <= 1'b0;
			last_s1       <= 1'b0;
			v_s2          <= 1'b0;
			last_s2       <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			best_found_q  <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			v_s1    <= rd_en;
			last_s1 <= rd_en && (cnt_q == LAST_IDX);
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (face_invalid) begin
							done_q <= 1'b1;
						end else begin
							state_q       <= S_SCAN;
							cnt_q         <= '0;
							match_found_q <= 1'b0;
							free_found_q  <= 1'b0;
							best_found_q  <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (v_s2) begin
						if (match_s2) begin
							match_found_q <= 1'b1;
						end
						if (!used_s2) begin
							free_found_q <= 1'b1;
						end
						if (contain_s2 && better) begin
							best_found_q <= 1'b1;
						end
						if (last_s2) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command, pipe and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= nrrt_pkg::op_t'(operation);
			first_q  <= range_first;
			last_q   <= range_last;
			node_q   <= lookup_node;
			gw_q     <= GW_W'(gateway_in);
			status_q <= nrrt_pkg::ST_INVALID;
			gw_out_q <= '0;
		end
		if (state_q == S_FINISH) begin
			status_q <= fin_status;
			gw_out_q <= fin_gw;
		end

		idx_s1 <= cnt_q[AW-1:0];

		// stage 2: compare one row against the command
		idx_s2     <= idx_s1;
		used_s2    <= r_valid;
		match_s2   <= r_valid && (r_first == first_q) && (r_last == last_q);
		contain_s2 <= r_valid && (r_first <= node_q) && (r_last >= node_q);
		size_s2    <= r_last - r_first;
		first_s2   <= r_first;
		gw_s2      <= r_gw;

		// fold the row into the running results, lowest slot first
		if ((state_q == S_SCAN) && v_s2) begin
			if (match_s2 && !match_found_q) begin
				match_idx_q <= idx_s2;
			end
			if (!used_s2 && !free_found_q) begin
				free_idx_q <= idx_s2;
			end
			if (contain_s2 && better) begin
				best_size_q  <= size_s2;
				best_first_q <= first_s2;
				best_gw_q    <= gw_s2;
			end
		end
	end

	nrrt_ram #(
		.WIDTH(ROW_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(cnt_q[AW-1:0]),
		.rd_data(rd_data)
	);

	assign done        = done_q;
	assign status      = status_q;
	assign gateway_out = nrrt_pkg::GW_PORT_W'(gw_out_q);

endmodule

`default_nettype wire

// File: src/nrrt_chk.sv
// ----------------------------------------------------------------------------
// nrrt_chk: port-level checks for the route table
// watches command and result ports over time
// ----------------------------------------------------------------------------
`default_nettype none

module nrrt_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [2:0]  status,
	input wire logic [15:0] gateway_out
);

	// a result is only shown once the block is free again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted command either starts a scan or answers at once
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command produced no activity");

	// a gateway is only reported with a found status
	a_gw_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != nrrt_pkg::ST_OK)) |-> (gateway_out == '0))
		else $error("gateway on a failed result");

	// every result follows a transfer or a scan
	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start))
		)
		else $error("result without a command");

endmodule

bind narrowest_range_route_table_top nrrt_chk u_nrrt_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.gateway_out(gateway_out)
);

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the narrowest range route table
// drives add, update, remove and lookup commands through start/busy, predicts
// each status and gateway from a shadow of the table and compares every done
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int TABLE_ENTRIES = 64;
	localparam int GATEWAY_BITS  = 16;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int QUIET_ITEMS   = 200;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int MAX_PRINTS    = 50;
	// longest command scans every row and adds a small pipe delay
	localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 8;

	localparam logic [63:0] NODE_MAX = '1;
	localparam logic [63:0] NODE_MID = 64'h8000_0000_0000_0000;
	localparam logic [15:0] GW_MASK  = 16'((32'd1 << GATEWAY_BITS) - 1);

	// one command as presented on the command ports
	typedef struct {
		nrrt_pkg::op_t op;
		logic [63:0]   first;
		logic [63:0]   last;
		logic [63:0]   node;
		logic [15:0]   gw;
	} route_cmd_t;

	// what the block should answer to one command
	typedef struct {
		nrrt_pkg::status_t st;
		logic [15:0]       gw;
	} route_answer_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	nrrt_pkg::op_t operation = nrrt_pkg::OP_ADD;
	logic [63:0]   range_first = '0;
	logic [63:0]   range_last = '0;
	logic [63:0]   lookup_node = '0;
	logic [15:0]   gateway_in = '0;
	logic          busy;
	logic          done;
	logic [2:0]    status;
	logic [15:0]   gateway_out;

	// commands waiting to be driven, answers waiting to come back
	route_cmd_t    cmd_queue[$];
	route_answer_t route_answers[$];

	// shadow of the route table, updated on every command transfer
	bit          route_live[TABLE_ENTRIES];
	logic [63:0] route_first[TABLE_ENTRIES];
	logic [63:0] route_last[TABLE_ENTRIES];
	logic [15:0] route_gw[TABLE_ENTRIES];

	// ranges the stimulus believes are in the table, used only to aim commands
	logic [63:0] plan_first[$];
	logic [63:0] plan_last[$];

	int            mismatches = 0;
	int            cycle_count = 0;
	int            cmds_issued = 0;
	int            quiet_from = 0;
	int            idle_left = 0;
	route_answer_t want_answer;

	narrowest_range_route_table_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.GATEWAY_BITS (GATEWAY_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.range_first(range_first),
		.range_last (range_last),
		.lookup_node(lookup_node),
		.gateway_in (gateway_in),
		.done       (done),
		.status     (status),
		.gateway_out(gateway_out)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// table predictor
	// ------------------------------------------------------------------

	// slot holding exactly [first, last], -1 when absent
	function automatic int route_slot(input logic [63:0] first, input logic [63:0] last);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (route_live[i] && route_first[i] == first && route_last[i] == last)
				return i;
		return -1;
	endfunction

	// applies one command to the shadow table and returns the expected answer
	function automatic route_answer_t route_apply(input route_cmd_t c);
		route_answer_t ans;
		int            hit;
		int            best;
		logic [63:0]   best_size;
		logic [63:0]   best_first;
		logic [63:0]   span;
		ans.st = nrrt_pkg::ST_OK;
		ans.gw = '0;
		best = -1;
		best_size = '0;
		best_first = '0;
		case (c.op)
			nrrt_pkg::OP_ADD: begin
				if (c.first == 0 || c.first > c.last) begin
					ans.st = nrrt_pkg::ST_INVALID;
				end else if (route_slot(c.first, c.last) >= 0) begin
					ans.st = nrrt_pkg::ST_DUPLICATE;
				end else begin
					// new range takes the lowest free slot
					hit = -1;
					for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
						if (!route_live[i])
							hit = i;
					if (hit < 0) begin
						ans.st = nrrt_pkg::ST_FULL;
					end else begin
						route_live[hit] = 1'b1;
						route_first[hit] = c.first;
						route_last[hit] = c.last;
						route_gw[hit] = c.gw & GW_MASK;
					end
				end
			end
			nrrt_pkg::OP_UPDATE: begin
				hit = route_slot(c.first, c.last);
				if (hit < 0)
					ans.st = nrrt_pkg::ST_UNKNOWN;
				else
					route_gw[hit] = c.gw & GW_MASK;
			end
			nrrt_pkg::OP_REMOVE: begin
				hit = route_slot(c.first, c.last);
				if (hit < 0)
					ans.st = nrrt_pkg::ST_UNKNOWN;
				else
					route_live[hit] = 1'b0;
			end
			default: begin
				if (c.node == 0) begin
					ans.st = nrrt_pkg::ST_INVALID;
				end else begin
					// narrowest containing range, lower first node on a tie
					for (int i = 0; i < TABLE_ENTRIES; i++) begin
						if (route_live[i] && route_first[i] <= c.node && route_last[i] >= c.node) begin
							span = route_last[i] - route_first[i];
							if (best < 0 || span < best_size ||
									(span == best_size && route_first[i] < best_first)) begin
								best = i;
								best_size = span;
								best_first = route_first[i];
							end
						end
					end
					if (best < 0)
						ans.st = nrrt_pkg::ST_UNKNOWN;
					else
						ans.gw = route_gw[best];
				end
			end
		endcase
		return ans;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic int plan_index(input logic [63:0] first, input logic [63:0] last);
		for (int i = 0; i < plan_first.size(); i++)
			if (plan_first[i] == first && plan_last[i] == last)
				return i;
		return -1;
	endfunction

	// queues one command and keeps the plan of live ranges in step with it
	function automatic void queue_cmd(input nrrt_pkg::op_t op, input logic [63:0] first,
			input logic [63:0] last, input logic [63:0] node, input logic [15:0] gw);
		route_cmd_t c;
		int         idx;
		c.op = op;
		c.first = first;
		c.last = last;
		c.node = node;
		c.gw = gw;
		cmd_queue.push_back(c);
		idx = plan_index(first, last);
		if (op == nrrt_pkg::OP_ADD && first != 0 && first <= last && idx < 0 &&
				plan_first.size() < TABLE_ENTRIES) begin
			plan_first.push_back(first);
			plan_last.push_back(last);
		end else if (op == nrrt_pkg::OP_REMOVE && idx >= 0) begin
			plan_first.delete(idx);
			plan_last.delete(idx);
		end
	endfunction

	// well-formed range from one of a few clusters, so ranges nest and overlap
	function automatic void pick_range(output logic [63:0] first, output logic [63:0] last);
		logic [63:0] span;
		case ($urandom_range(0, 3))
			0: begin
				first = 64'($urandom_range(1, 60));
				last = first + 64'($urandom_range(0, 40));
			end
			1: begin
				last = NODE_MAX - 64'($urandom_range(0, 40));
				first = last - 64'($urandom_range(0, 40));
			end
			2: begin
				first = rnd64() >> $urandom_range(0, 63);
				if (first == 0)
					first = 64'd1;
				span = rnd64() >> $urandom_range(0, 63);
				last = (first > NODE_MAX - span) ? NODE_MAX : first + span;
			end
			default: begin
				first = NODE_MID - 64'($urandom_range(0, 30));
				last = NODE_MID + 64'($urandom_range(0, 30));
			end
		endcase
	endfunction

	// range that can never be in the table: first node zero or reversed
	function automatic void pick_bad_range(output logic [63:0] first, output logic [63:0] last);
		logic [63:0] a;
		logic [63:0] b;
		pick_range(a, b);
		if ($urandom_range(0, 1) == 0) begin
			first = '0;
			last = $urandom_range(0, 1) ? rnd64() : b;
		end else begin
			first = (a == b) ? a : b;
			last = (a == b) ? a - 1 : a;
		end
	endfunction

	// planned range, or a fresh one when the plan is empty
	function automatic void pick_planned(output logic [63:0] first, output logic [63:0] last);
		int idx;
		if (plan_first.size() == 0) begin
			pick_range(first, last);
		end else begin
			idx = $urandom_range(0, plan_first.size() - 1);
			first = plan_first[idx];
			last = plan_last[idx];
		end
	endfunction

	function automatic logic [63:0] pick_node();
		logic [63:0] first;
		logic [63:0] last;
		int          sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return '0;
		if (sel < 4)
			return rnd64();
		if (sel < 8)
			pick_range(first, last);
		else
			pick_planned(first, last);
		case ($urandom_range(0, 3))
			0: return first;
			1: return last;
			default: return first + rnd64() % (last - first + 1);
		endcase
	endfunction

	function automatic void queue_random_cmd();
		logic [63:0] first;
		logic [63:0] last;
		int          w;
		int          sub;
		w = $urandom_range(0, 99);
		sub = $urandom_range(0, 9);
		if (w < 30) begin
			if (sub == 0)
				pick_planned(first, last);
			else if (sub == 1)
				pick_bad_range(first, last);
			else if (sub == 2) begin
				first = rnd64();
				last = rnd64();
			end else
				pick_range(first, last);
			queue_cmd(nrrt_pkg::OP_ADD, first, last, rnd64(), 16'($urandom));
		end else if (w < 62) begin
			if (sub < 7)
				pick_planned(first, last);
			else if (sub == 7)
				pick_bad_range(first, last);
			else
				pick_range(first, last);
			queue_cmd(w < 45 ? nrrt_pkg::OP_UPDATE : nrrt_pkg::OP_REMOVE, first, last,
					rnd64(), 16'($urandom));
		end else begin
			queue_cmd(nrrt_pkg::OP_LOOKUP, rnd64(), rnd64(), pick_node(), 16'($urandom));
		end
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// ------------------------------------------------------------------
	// command driver: presents queued commands, idles in random bursts
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			operation <= nrrt_pkg::OP_ADD;
			range_first <= '0;
			range_last <= '0;
			lookup_node <= '0;
			gateway_in <= '0;
			idle_left <= 0;
		end else begin
			// a transfer: predict its answer from the values still on the ports
			if (start && !busy)
				route_answers.push_back(route_apply('{operation, range_first, range_last,
						lookup_node, gateway_in}));
			if (start && busy) begin
				// hold the command until the block takes it
			end else if (idle_left != 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (cmd_queue.size() != 0) begin
				operation <= cmd_queue[0].op;
				range_first <= cmd_queue[0].first;
				range_last <= cmd_queue[0].last;
				lookup_node <= cmd_queue[0].node;
				gateway_in <= cmd_queue[0].gw;
				void'(cmd_queue.pop_front());
				start <= 1'b1;
				cmds_issued++;
				// gap after this transfer, none in the closing stretch
				if (cmds_issued < quiet_from && $urandom_range(0, 7) == 0)
					idle_left <= $urandom_range(1, 19);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor: each done pulse against the oldest expected answer
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (route_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected result, status %0d gateway %h",
						status, gateway_out));
			end else begin
				want_answer = route_answers.pop_front();
				if (status !== want_answer.st)
					report_mismatch($sformatf("status %0d, expected %0d", status, want_answer.st));
				if (gateway_out !== want_answer.gw)
					report_mismatch($sformatf("gateway %h, expected %h", gateway_out,
							want_answer.gw));
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int          target;
		int          burst;
		logic [63:0] first;
		logic [63:0] last;

		// directed: face-invalid commands, empty table, nesting, ties, extremes
		queue_cmd(nrrt_pkg::OP_LOOKUP, rnd64(), rnd64(), 64'd0, 16'hFFFF);
		queue_cmd(nrrt_pkg::OP_LOOKUP, rnd64(), rnd64(), 64'd1, 16'h0000);
		queue_cmd(nrrt_pkg::OP_UPDATE, 64'd1, 64'd5, '0, 16'h1111);
		queue_cmd(nrrt_pkg::OP_REMOVE, 64'd1, 64'd5, '0, 16'h0000);
		queue_cmd(nrrt_pkg::OP_ADD, 64'd0, 64'd9, '0, 16'h2222);
		queue_cmd(nrrt_pkg::OP_ADD, 64'd9, 64'd3, '0, 16'h3333);
		queue_cmd(nrrt_pkg::OP_ADD, 64'd1, NODE_MAX, '0, 16'hFFFF);
		queue_cmd(nrrt_pkg::OP_ADD, 64'd1, NODE_MAX, '0, 16'h0001);
		queue_cmd(nrrt_pkg::OP_ADD, NODE_MAX, NODE_MAX, '0, 16'h0000);
		queue_cmd(nrrt_pkg::OP_ADD, 64'd10, 64'd20, '0, 16'h1234);
		queue_cmd(nrrt_pkg::OP_ADD, 64'd5, 64'd15, '0, 16'h0555);
		queue_cmd(nrrt_pkg::OP_ADD, 64'd15, 64'd20, '0, 16'h0AAA);
		// 12 sits in two ranges of equal size: lower first node wins
		queue_cmd(nrrt_pkg::OP_LOOKUP, NODE_MAX, '0, 64'd12, 16'hFFFF);
		queue_cmd(nrrt_pkg::OP_LOOKUP, '0, NODE_MAX, 64'd15, 16'h0000);
		queue_cmd(nrrt_pkg::OP_LOOKUP, rnd64(), rnd64(), NODE_MAX, 16'h0000);
		queue_cmd(nrrt_pkg::OP_LOOKUP, rnd64(), rnd64(), 64'd2, 16'h0000);
		queue_cmd(nrrt_pkg::OP_UPDATE, 64'd10, 64'd20, '0, 16'h7E7E);
		queue_cmd(nrrt_pkg::OP_REMOVE, 64'd15, 64'd20, '0, 16'h0000);
		queue_cmd(nrrt_pkg::OP_REMOVE, 64'd15, 64'd20, '0, 16'h0000);
		queue_cmd(nrrt_pkg::OP_LOOKUP, rnd64(), rnd64(), 64'd18, 16'h0000);
		queue_cmd(nrrt_pkg::OP_UPDATE, 64'd0, 64'd0, '0, 16'hFFFF);
		queue_cmd(nrrt_pkg::OP_REMOVE, 64'd20, 64'd10, '0, 16'h0000);
		queue_cmd(nrrt_pkg::OP_ADD, NODE_MAX - 1, NODE_MAX, NODE_MAX, 16'h8001);
		queue_cmd(nrrt_pkg::OP_LOOKUP, rnd64(), rnd64(), NODE_MID, 16'h0000);

		// random part in episodes: fill to full, drain, or a mixed stretch
		target = cmd_queue.size() + RANDOM_ITEMS;
		while (cmd_queue.size() < target) begin
			case ($urandom_range(0, 9))
				0: begin
					// fill to capacity, then a few adds that must come back full
					burst = 0;
					while (plan_first.size() < TABLE_ENTRIES && burst < 4 * TABLE_ENTRIES) begin
						pick_range(first, last);
						queue_cmd(nrrt_pkg::OP_ADD, first, last, rnd64(), 16'($urandom));
						burst++;
					end
					repeat ($urandom_range(1, 3)) begin
						pick_range(first, last);
						queue_cmd(nrrt_pkg::OP_ADD, first, last, rnd64(), 16'($urandom));
					end
				end
				1: begin
					if (plan_first.size() != 0) begin
						burst = $urandom_range(1, plan_first.size());
						repeat (burst) begin
							pick_planned(first, last);
							queue_cmd(nrrt_pkg::OP_REMOVE, first, last, rnd64(), 16'($urandom));
						end
					end
				end
				default: begin
					repeat ($urandom_range(20, 60))
						queue_random_cmd();
				end
			endcase
		end
		quiet_from = cmd_queue.size() - QUIET_ITEMS;

		// reset once; the block then clears its table with busy high
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// everything transferred and every answer back
		while (cmd_queue.size() != 0 || start || route_answers.size() != 0)
			@(negedge clk);
		// allow for any stray result after the last one expected
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
